/* sv/smf_pkg.sv */
`default_nettype none
package smf_pkg;
  localparam int unsigned WordW   = 32;
  localparam int unsigned FracW   = 23;
  localparam int unsigned ExpW    = 8;
  localparam int unsigned LowW    = 11;
  localparam int unsigned HighW   = 13;
  localparam int unsigned SumW    = 26;
  localparam logic [8:0]  ExpBias = 9'h081;
  localparam logic [SumW-1:0] MantBias = 26'h2;

  typedef struct packed {
    logic              sign;
    logic [8:0]        esum;
    logic [HighW-1:0]  ah;
    logic [LowW-1:0]   al;
    logic [HighW-1:0]  bh;
    logic [LowW-1:0]   bl;
  } split_t;

  typedef struct packed {
    logic              sign;
    logic [8:0]        esum;
    logic [SumW-1:0]   hh;
    logic [SumW-1:0]   hl;
    logic [SumW-1:0]   lh;
  } part_t;

  typedef struct packed {
    logic              sign;
    logic [8:0]        esum;
    logic [SumW-1:0]   sum;
  } msum_t;
endpackage
`default_nettype wire

/* sv/smf_mul.sv */
`default_nettype none
// partial products of the split mantissas, one register stage
module smf_mul (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            vld_i,
  input  smf_pkg::split_t      d_i,
  output logic                 vld_o,
  output smf_pkg::part_t       d_o
);
  logic vld_r;
  smf_pkg::part_t d_r, d_nxt;

  always_comb begin
    d_nxt.sign = d_i.sign;
    d_nxt.esum = d_i.esum;
    d_nxt.hh = smf_pkg::SumW'(d_i.ah * d_i.bh);
    d_nxt.hl = smf_pkg::SumW'(d_i.ah * d_i.bl);
    d_nxt.lh = smf_pkg::SumW'(d_i.al * d_i.bh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    d_r <= d_nxt;
  end

  assign vld_o = vld_r;
  assign d_o = d_r;
endmodule
`default_nettype wire

/* sv/smf_norm.sv */
`default_nettype none
// mantissa sum stage then normalize and pack stage
module smf_norm (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            vld_i,
  input  smf_pkg::part_t       d_i,
  output logic                 vld_o,
  output logic [31:0]          word_o
);
  logic vld1_r, vld2_r;
  smf_pkg::msum_t s_r, s_nxt;
  logic [31:0] w_r, w_nxt;
  logic top;
  logic [7:0] exp_f;

  always_comb begin
    s_nxt.sign = d_i.sign;
    s_nxt.esum = d_i.esum;
    s_nxt.sum = d_i.hh + (d_i.hl >> smf_pkg::LowW) + (d_i.lh >> smf_pkg::LowW)
                + smf_pkg::MantBias;
  end

  always_comb begin
    top = s_r.sum[25];
    if (!s_r.esum[8]) begin
      exp_f = 8'h00;
    end else if (top) begin
      exp_f = s_r.esum[7:0] + 8'd1;
    end else begin
      exp_f = s_r.esum[7:0];
    end
    w_nxt = {s_r.sign, exp_f, top ? s_r.sum[24:2] : s_r.sum[23:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
    s_r <= s_nxt;
    w_r <= w_nxt;
  end

  assign vld_o = vld2_r;
  assign word_o = w_r;
endmodule
`default_nettype wire

/* sv/split_mantissa_float32_multiplier.sv */
`default_nettype none
// Approximate single-precision multiplier, fully pipelined: one request per
// clock, busy is always low, and out_valid strobes the product after the
// input split, partial multiply, mantissa sum and normalize/pack registers.
// The receiver cannot stall; each product is shown for one cycle only.
module split_mantissa_float32_multiplier (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  output logic [31:0]      out_product
);
  logic vld0_r, vld1;
  smf_pkg::split_t sp_r, sp_nxt;
  smf_pkg::part_t pp;

  always_comb begin
    sp_nxt.sign = in_operand_a[31] ^ in_operand_b[31];
    sp_nxt.esum = {1'b0, in_operand_a[30:23]} + {1'b0, in_operand_b[30:23]}
                  + smf_pkg::ExpBias;
    sp_nxt.ah = {1'b1, in_operand_a[22:11]};
    sp_nxt.al = in_operand_a[10:0];
    sp_nxt.bh = {1'b1, in_operand_b[22:11]};
    sp_nxt.bl = in_operand_b[10:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start;
    end
    sp_r <= sp_nxt;
  end

  assign busy = 1'b0;

  smf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .vld_i(vld0_r), .d_i(sp_r), .vld_o(vld1), .d_o(pp)
  );

  smf_norm u_norm (
    .clk(clk), .rst_n(rst_n), .vld_i(vld1), .d_i(pp),
    .vld_o(out_valid), .word_o(out_product)
  );
endmodule
`default_nettype wire

/* tb/sv/smf_checker.sv */
`timescale 1ns / 1ps
module smf_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  input  wire logic        out_valid,
  input  wire logic [31:0] out_product,
  output int               fail_count,
  output int               pending
);
  logic [31:0] product_q[$];

  function automatic logic [31:0] approx_product(logic [31:0] a, logic [31:0] b);
    logic [smf_pkg::HighW-1:0] ah, bh;
    logic [smf_pkg::LowW-1:0] al, bl;
    logic [smf_pkg::SumW-1:0] hh, hl, lh, msum;
    logic [8:0] esum;
    logic [smf_pkg::ExpW-1:0] exp_f;
    logic [smf_pkg::FracW-1:0] frac;
    ah = {1'b1, a[22:11]};
    bh = {1'b1, b[22:11]};
    al = a[10:0];
    bl = b[10:0];
    hh = smf_pkg::SumW'(ah) * smf_pkg::SumW'(bh);
    hl = smf_pkg::SumW'(ah) * smf_pkg::SumW'(bl);
    lh = smf_pkg::SumW'(al) * smf_pkg::SumW'(bh);
    msum = hh + (hl >> smf_pkg::LowW) + (lh >> smf_pkg::LowW) + smf_pkg::MantBias;
    esum = 9'(a[30:23]) + 9'(b[30:23]) + smf_pkg::ExpBias;
    // top bit of the sum shifts one more place and bumps the exponent
    if (!esum[8]) exp_f = '0;
    else if (msum[25]) exp_f = esum[7:0] + 8'd1;
    else exp_f = esum[7:0];
    frac = msum[25] ? msum[24:2] : msum[23:1];
    return {a[31] ^ b[31], exp_f, frac};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %08h want %08h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (product_q.size() == 0) report_mismatch("unexpected product", out_product, 32'h0);
        else begin
          logic [31:0] want;
          want = product_q.pop_front();
          if (out_product !== want) report_mismatch("product", out_product, want);
        end
      end
      if (start && !busy) product_q.push_back(approx_product(in_operand_a, in_operand_b));
    end
    pending = product_q.size();
  end
endmodule

/* tb/sv/tb_split_mantissa_float32_multiplier.sv */
`timescale 1ns / 1ps
module tb_split_mantissa_float32_multiplier;
  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic [31:0] in_operand_a = 0, in_operand_b = 0;
  wire logic busy, out_valid;
  wire logic [31:0] out_product;
  int fail_count, pending;

  split_mantissa_float32_multiplier dut (.*);
  smf_checker chk (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] rand_operand();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: w[30:23] = 8'hFF;
      1: w[30:23] = 8'h00;
      2: w[30:23] = 8'(8'h7F + $urandom_range(0, 3) - 1);
      3: w[22:0] = $urandom_range(0, 1) ? '1 : '0;
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_request(logic [31:0] a, logic [31:0] b, bit calm);
    while (!calm && $urandom_range(0, 99) < 8) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [31:0] dir_a[12] = '{32'h0, 32'hFFFFFFFF, 32'h3F800000, 32'h7F800000,
      32'h7FC00000, 32'h00000001, 32'h80000000, 32'h7F7FFFFF, 32'h3FFFFFFF,
      32'h40000000, 32'h007FFFFF, 32'hC0400000};
    logic [31:0] dir_b[12] = '{32'h0, 32'hFFFFFFFF, 32'h3F800000, 32'h7F800000,
      32'hFF800000, 32'h00000001, 32'h00000000, 32'h7F7FFFFF, 32'h3FFFFFFF,
      32'hBF800000, 32'h00800000, 32'h40400000};
    int guard;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 12; i++) send_request(dir_a[i], dir_b[i], 0);
    for (int i = 0; i < 1300; i++)
      send_request(rand_operand(), rand_operand(), i >= 400 && i < 700);
    start <= 0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_split_mantissa_float32_multiplier: done, clean");
    else
      $display("tb_split_mantissa_float32_multiplier: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_split_mantissa_float32_multiplier: done, errors");
    $finish;
  end
endmodule
